@@ sv/ale_pkg.sv @@
package ale_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 25;
  localparam int MEM_W      = 24;
  localparam int MODE_W     = 2;
  localparam int SHIFT_W    = 4;
  localparam int RATIO_W    = 7;
  localparam int DELAY_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Default delay line depth in samples.
  localparam int DEFAULT_MAX_DELAY = 8192;

  // Saturation limits for the output and for the stored echo sum.
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int MEM_MAX    = 8388607;
  localparam int MEM_MIN    = -8388608;

  // Division by 100 as a multiply by ceil(2^36 / 100) and a shift by 36.
  // Exact for every product below 2^30, which covers 2^23 * 127.
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_100 = 30'd687194768;

  // Largest lowpass shift actually applied.
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_SHIFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_RATIO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_STORE_INPUT = 3'd4;

  // Effect modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_PASS    = 2'd0,
    MODE_LOWPASS = 2'd1,
    MODE_LP_ECHO = 2'd2,
    MODE_ECHO    = 2'd3
  } effect_mode_t;

  // Configuration reset values.
  localparam effect_mode_t        RST_EFFECT_MODE   = MODE_PASS;
  localparam logic [SHIFT_W-1:0]  RST_LOWPASS_SHIFT = 4'd5;
  localparam logic [RATIO_W-1:0]  RST_ECHO_RATIO    = 7'd25;
  localparam logic [DELAY_W-1:0]  RST_ECHO_DELAY    = 14'd4410;

  // One input item: a stereo pair and the start-of-sound flag.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       first_sample;
  } in_item_t;

  // One result item: the processed stereo pair.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_item_t;

  // Control shared by both channel lanes.
  typedef struct packed {
    logic accept;       // item taken this cycle
    logic first;        // accepted item starts a new sound
    logic lp_en;        // lowpass active
    logic echo_en;      // echo active
    logic fb_store;     // delay line stores the clamped output
    logic store_input;  // delay line stores the input sample
    logic hist_ok;      // stage 1 item has a valid delayed sample
    logic ld2;          // stage 2 loads from stage 1
    logic ld3;          // stage 3 loads from stage 2
    logic ld_out;       // output register loads from stage 3
    logic mem_we;       // stage 3 writes its delay line slot
  } lane_ctrl_t;

endpackage

@@ sv/audio_lowpass_echo_effect.sv @@
// Stereo lowpass and echo effect. Each item is one signed 16-bit stereo pair
// and yields one processed pair, which passes through stages 1, 2 and 3 and
// the output register before it appears on the output. Two identical channel
// lanes run side by side: a leaky-integrator lowpass, then an echo that adds
// the delay line entry from echo_delay items earlier times echo_ratio/100 and
// clamps to 16 bits. The echo path is a three-stage pipeline (delay line
// read, gain multiply, divide by 100 through a reciprocal multiply), and the
// delay line slot is written at its end. The block takes one item per cycle
// while the output is not held back by out_ready; in the echo modes with an
// effective delay of one to three items, an item waits until the earlier item
// it echoes has written its slot. Each lane owns a MAX_DELAY by 24-bit delay
// line RAM; it is never cleared, and no slot is read before the current sound
// has written it. Configuration is written through cfg_we / cfg_index /
// cfg_wdata; the user must write it only while no item is in flight, which the
// block itself does not enforce. Reset is synchronous and active low.
module audio_lowpass_echo_effect #(
  parameter int MAX_DELAY = ale_pkg::DEFAULT_MAX_DELAY
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ale_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ale_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [ale_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ale_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ale_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);

  effect_mode_t         effect_mode_r;
  logic [SHIFT_W-1:0]   lp_shift_r;
  logic [RATIO_W-1:0]   echo_ratio_r;
  logic [DELAY_W-1:0]   echo_delay_r;
  logic                 store_input_r;
  logic [SHIFT_W-1:0]   lp_shift_eff;

  lane_ctrl_t           ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic signed [SAMPLE_W-1:0] y_left;
  logic signed [SAMPLE_W-1:0] y_right;
  out_item_t            out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r <= RST_EFFECT_MODE;
      lp_shift_r    <= RST_LOWPASS_SHIFT;
      echo_ratio_r  <= RST_ECHO_RATIO;
      echo_delay_r  <= RST_ECHO_DELAY;
      store_input_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EFFECT_MODE: begin
          effect_mode_r <= effect_mode_t'(cfg_wdata[MODE_W-1:0]);
        end
        CFG_LOWPASS_SHIFT: begin
          lp_shift_r <= cfg_wdata[SHIFT_W-1:0];
        end
        CFG_ECHO_RATIO: begin
          echo_ratio_r <= cfg_wdata[RATIO_W-1:0];
        end
        CFG_ECHO_DELAY: begin
          echo_delay_r <= cfg_wdata[DELAY_W-1:0];
        end
        CFG_ECHO_STORE_INPUT: begin
          store_input_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Shifts beyond the limit act as the limit.
  assign lp_shift_eff = (lp_shift_r > MAX_SHIFT) ? MAX_SHIFT : lp_shift_r;

  ale_ctrl #(
    .MAX_DELAY (MAX_DELAY)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_first         (in_data.first_sample),
    .out_ready        (out_ready),
    .effect_mode      (effect_mode_r),
    .echo_store_input (store_input_r),
    .echo_delay       (echo_delay_r),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .ctl              (ctl),
    .rd_addr          (rd_addr),
    .wr_addr          (wr_addr)
  );

  ale_lane #(
    .MAX_DELAY (MAX_DELAY)
  ) u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .lp_shift   (lp_shift_eff),
    .echo_ratio (echo_ratio_r),
    .sample     (in_data.sample_left),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .y          (y_left)
  );

  ale_lane #(
    .MAX_DELAY (MAX_DELAY)
  ) u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .lp_shift   (lp_shift_eff),
    .echo_ratio (echo_ratio_r),
    .sample     (in_data.sample_right),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .y          (y_right)
  );

  // Merge both lanes into the output register.
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_data_r.out_left  <= y_left;
      out_data_r.out_right <= y_right;
    end
  end

  assign out_data = out_data_r;

endmodule

@@ sv/ale_ram.sv @@
module ale_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ale_lane.sv @@
module ale_lane #(
  parameter int MAX_DELAY = ale_pkg::DEFAULT_MAX_DELAY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ale_pkg::lane_ctrl_t                 ctl,
  input  logic [ale_pkg::SHIFT_W-1:0]         lp_shift,
  input  logic [ale_pkg::RATIO_W-1:0]         echo_ratio,
  input  logic signed [ale_pkg::SAMPLE_W-1:0] sample,
  input  logic [$clog2(MAX_DELAY)-1:0]        rd_addr,
  input  logic [$clog2(MAX_DELAY)-1:0]        wr_addr,
  output logic signed [ale_pkg::SAMPLE_W-1:0] y
);

  import ale_pkg::*;

  localparam int PROD_W  = MEM_W + RATIO_W;
  localparam int QPROD_W = PROD_W + RECIP_W;
  localparam int Q_W     = QPROD_W - RECIP_SHIFT;
  localparam int SUM_W   = ACC_W + 1;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(SAMPLE_MIN);
  localparam logic signed [SUM_W-1:0] ST_MAX  = SUM_W'(MEM_MAX);
  localparam logic signed [SUM_W-1:0] ST_MIN  = SUM_W'(MEM_MIN);

  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_cur;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    lp_y;
  logic signed [ACC_W-1:0]    x_ext;
  logic signed [ACC_W-1:0]    b_cur;

  logic signed [ACC_W-1:0]    s1_b_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;
  logic [MEM_W-1:0]           mem_rdata;
  logic [MEM_W-1:0]           mem_wdata;
  logic [MEM_W-1:0]           dly;
  logic                       dly_neg;
  logic [MEM_W-1:0]           dly_mag;
  logic [PROD_W-1:0]          p_nxt;

  logic [PROD_W-1:0]          s2_p_r;
  logic                       s2_neg_r;
  logic signed [ACC_W-1:0]    s2_b_r;
  logic signed [SAMPLE_W-1:0] s2_x_r;
  logic [QPROD_W-1:0]         qprod;

  logic [Q_W-1:0]             s3_q_r;
  logic                       s3_neg_r;
  logic signed [ACC_W-1:0]    s3_b_r;
  logic signed [SAMPLE_W-1:0] s3_x_r;

  logic signed [SUM_W-1:0]    q_ext;
  logic signed [SUM_W-1:0]    echo_term;
  logic signed [SUM_W-1:0]    b_ext;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_c16;
  logic signed [SUM_W-1:0]    sum_c24;
  logic signed [SAMPLE_W-1:0] sat16;

  // Leaky integrator: output is the accumulator shifted right, then the
  // accumulator gains the input minus that output.
  always_comb begin
    acc_cur = ctl.first ? '0 : acc_r;
    x_ext   = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    lp_y    = acc_cur >>> lp_shift;
    acc_nxt = acc_cur - lp_y + x_ext;
    b_cur   = ctl.lp_en ? lp_y : x_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.accept) begin
      acc_r <= ctl.lp_en ? acc_nxt : acc_cur;
    end
  end

  // Stage 1: the delay line read is issued with the accepted item.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_b_r <= b_cur;
      s1_x_r <= sample;
    end
  end

  ale_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_DELAY)
  ) u_mem (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (wr_addr),
    .wdata (mem_wdata),
    .re    (ctl.accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // Delayed sample reads as zero until enough history exists; the gain
  // is applied to its magnitude so the division truncates toward zero.
  always_comb begin
    dly     = ctl.hist_ok ? mem_rdata : '0;
    dly_neg = dly[MEM_W-1];
    dly_mag = dly_neg ? (~dly + 1'b1) : dly;
    p_nxt   = PROD_W'(dly_mag) * PROD_W'(echo_ratio);
  end

  // Stage 2: magnitude times ratio.
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      s2_p_r   <= p_nxt;
      s2_neg_r <= dly_neg;
      s2_b_r   <= s1_b_r;
      s2_x_r   <= s1_x_r;
    end
  end

  // Divide by 100 through the reciprocal.
  assign qprod = QPROD_W'(s2_p_r) * QPROD_W'(RECIP_100);

  // Stage 3: quotient ready.
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      s3_q_r   <= qprod[RECIP_SHIFT +: Q_W];
      s3_neg_r <= s2_neg_r;
      s3_b_r   <= s2_b_r;
      s3_x_r   <= s2_x_r;
    end
  end

  // Echo sum, clamps, lane output and the value written to the delay line.
  always_comb begin
    q_ext     = SUM_W'(s3_q_r);
    echo_term = s3_neg_r ? -q_ext : q_ext;
    b_ext     = {s3_b_r[ACC_W-1], s3_b_r};
    sum       = b_ext + echo_term;

    if (sum > OUT_MAX) begin
      sum_c16 = OUT_MAX;
    end else if (sum < OUT_MIN) begin
      sum_c16 = OUT_MIN;
    end else begin
      sum_c16 = sum;
    end
    sat16 = sum_c16[SAMPLE_W-1:0];

    if (sum > ST_MAX) begin
      sum_c24 = ST_MAX;
    end else if (sum < ST_MIN) begin
      sum_c24 = ST_MIN;
    end else begin
      sum_c24 = sum;
    end

    y = ctl.echo_en ? sat16 : s3_b_r[SAMPLE_W-1:0];

    if (ctl.fb_store) begin
      mem_wdata = {{(MEM_W-SAMPLE_W){sat16[SAMPLE_W-1]}}, sat16};
    end else if (ctl.store_input) begin
      mem_wdata = {{(MEM_W-SAMPLE_W){s3_x_r[SAMPLE_W-1]}}, s3_x_r};
    end else begin
      mem_wdata = sum_c24[MEM_W-1:0];
    end
  end

endmodule

@@ sv/ale_ctrl.sv @@
module ale_ctrl #(
  parameter int MAX_DELAY = ale_pkg::DEFAULT_MAX_DELAY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_first,
  input  logic                         out_ready,
  input  ale_pkg::effect_mode_t        effect_mode,
  input  logic                         echo_store_input,
  input  logic [ale_pkg::DELAY_W-1:0]  echo_delay,
  output logic                         in_ready,
  output logic                         out_valid,
  output ale_pkg::lane_ctrl_t          ctl,
  output logic [$clog2(MAX_DELAY)-1:0] rd_addr,
  output logic [$clog2(MAX_DELAY)-1:0] wr_addr
);

  import ale_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int DW = $clog2(MAX_DELAY + 1);
  localparam int CW = (DW > DELAY_W) ? DW : DELAY_W;

  localparam logic [CW-1:0] MAX_C     = CW'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_DELAY - 1);
  localparam logic [DW-1:0] HIST_FULL = DW'(MAX_DELAY);

  logic [AW-1:0] w_r;
  logic [DW-1:0] hist_r;
  logic          s1_v_r;
  logic          s2_v_r;
  logic          s3_v_r;
  logic          out_v_r;
  logic [AW-1:0] s1_w_r;
  logic [AW-1:0] s2_w_r;
  logic [AW-1:0] s3_w_r;
  logic          s1_ok_r;

  logic          lp_en;
  logic          echo_en;
  logic [CW-1:0] dly_ext;
  logic [CW-1:0] d_eff;
  logic [CW-1:0] w_ext;
  logic [CW-1:0] r_ext;
  logic          hazard;
  logic          ld1;
  logic          ld2;
  logic          ld3;
  logic          ld_out;
  logic          accept;
  logic [AW-1:0] w_cur;
  logic [AW-1:0] w_inc;
  logic [DW-1:0] hist_cur;
  logic [DW-1:0] hist_inc;
  logic          hist_ok;

  // Mode decode and effective delay.
  always_comb begin
    lp_en   = (effect_mode == MODE_LOWPASS) || (effect_mode == MODE_LP_ECHO);
    echo_en = (effect_mode == MODE_LP_ECHO) || (effect_mode == MODE_ECHO);
    dly_ext = CW'(echo_delay);
    if (dly_ext == '0) begin
      d_eff = CW'(1);
    end else if (dly_ext > MAX_C) begin
      d_eff = MAX_C;
    end else begin
      d_eff = dly_ext;
    end
  end

  // Read slot is the write slot minus the delay, wrapped around the line.
  always_comb begin
    w_ext = CW'(w_r);
    if (w_ext >= d_eff) begin
      r_ext = w_ext - d_eff;
    end else begin
      r_ext = w_ext + (MAX_C - d_eff);
    end
    rd_addr = r_ext[AW-1:0];
  end

  // Hold off an item whose read slot is still owed by an item in flight.
  assign hazard = echo_en &&
                  ((s1_v_r && (s1_w_r == rd_addr)) ||
                   (s2_v_r && (s2_w_r == rd_addr)) ||
                   (s3_v_r && (s3_w_r == rd_addr)));

  // Each stage moves when the one after it is empty or moving.
  always_comb begin
    ld_out   = !out_v_r || out_ready;
    ld3      = !s3_v_r || ld_out;
    ld2      = !s2_v_r || ld3;
    ld1      = !s1_v_r || ld2;
    in_ready = ld1 && !hazard;
    accept   = in_valid && in_ready;
  end

  // Write slot and history count, cleared at the start of a sound.
  always_comb begin
    w_cur    = in_first ? '0 : w_r;
    hist_cur = in_first ? '0 : hist_r;
    w_inc    = (w_cur == LAST_SLOT) ? '0 : w_cur + 1'b1;
    hist_inc = (hist_cur == HIST_FULL) ? hist_cur : hist_cur + 1'b1;
    hist_ok  = CW'(hist_cur) >= d_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= '0;
      hist_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        w_r    <= echo_en ? w_inc : w_cur;
        hist_r <= echo_en ? hist_inc : hist_cur;
      end
      if (ld1) begin
        s1_v_r <= accept;
      end
      if (ld2) begin
        s2_v_r <= s1_v_r;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
      if (ld_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  // Slot addresses travel with their items.
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_w_r  <= w_cur;
      s1_ok_r <= hist_ok;
    end
    if (ld2) begin
      s2_w_r <= s1_w_r;
    end
    if (ld3) begin
      s3_w_r <= s2_w_r;
    end
  end

  assign wr_addr   = s3_w_r;
  assign out_valid = out_v_r;

  // Control bundle for both lanes.
  always_comb begin
    ctl.accept      = accept;
    ctl.first       = in_first;
    ctl.lp_en       = lp_en;
    ctl.echo_en     = echo_en;
    ctl.fb_store    = (effect_mode == MODE_LP_ECHO);
    ctl.store_input = echo_store_input;
    ctl.hist_ok     = s1_ok_r;
    ctl.ld2         = ld2;
    ctl.ld3         = ld3;
    ctl.ld_out      = ld_out;
    ctl.mem_we      = s3_v_r && ld_out && echo_en;
  end

endmodule
